// File: design/efg_pkg.sv
// Shared types and constants for the event flag group with waiter slots.
// Used by efg_match, efg_slot_table and event_flag_group_with_waiters.
package efg_pkg;

   localparam int EVENT_BITS = 32;
   localparam int TIMEOUT_BITS = 16;
   localparam int SLOT_BITS = 3;
   localparam int DEF_WAITER_SLOTS = 8;

   typedef enum logic [1:0] {
      OP_POST = 2'd0,
      OP_WAIT = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      RS_POST_DONE = 3'd0,
      RS_SATISFIED = 3'd1,
      RS_WOKEN     = 3'd2,
      RS_TIMED_OUT = 3'd3,
      RS_NO_WAIT   = 3'd4,
      RS_SLOT_BUSY = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WAIT,
      S_WALK,
      S_ACK
   } state_type;

   typedef struct packed {
      logic [1:0]              op;
      logic [EVENT_BITS-1:0]   value_bits;
      logic [EVENT_BITS-1:0]   post_mask;
      logic [SLOT_BITS-1:0]    waiter_slot;
      logic                    require_all;
      logic                    reset_first;
      logic                    consume;
      logic [TIMEOUT_BITS-1:0] timeout_ticks;
   } req_word_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [SLOT_BITS-1:0]  slot_id;
      logic [EVENT_BITS-1:0] matched_bits;
      logic [EVENT_BITS-1:0] previous_bits;
      logic [EVENT_BITS-1:0] events_now;
      logic                  last;
   } rsp_word_type;

   typedef struct packed {
      logic [EVENT_BITS-1:0]   interest;
      logic                    need_all;
      logic                    consume;
      logic                    endless;
      logic [TIMEOUT_BITS-1:0] ticks;
   } slot_entry_type;

   typedef struct packed {
      logic park;
      logic free;
      logic dec;
   } slot_cmd_type;

endpackage

// File: design/event_flag_group_with_waiters.sv
// Event flag word with WAITER_SLOTS waiter slots; a small sequencer walks the slot
// table through one shared match unit. Post and tick items are taken in the idle
// state, then walk every waiter slot (WAITER_SLOTS, 8 by default), one slot per
// cycle through the single match unit while no result word waits on a stalled
// port; a post then adds an acknowledgement state. A wait item is taken in the
// idle state and tested in the wait state. The wait and acknowledgement states
// also hold while a stalled result port has a word waiting. Results of a post
// come as woken words in ascending slot order and then the acknowledgement; the
// next item is taken while the final result waits in the output register.
// Depends on efg_pkg, efg_match and efg_slot_table.
module event_flag_group_with_waiters #(
   parameter int WAITER_SLOTS = efg_pkg::DEF_WAITER_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  efg_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output efg_pkg::rsp_word_type rsp_word
);
   import efg_pkg::*;

   localparam int IDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WAITER_SLOTS - 1);

   state_type             state_ff;
   state_type             state_in;
   req_word_type          req_ff;
   logic [EVENT_BITS-1:0] ew_ff;
   logic [EVENT_BITS-1:0] ew_in;
   logic [EVENT_BITS-1:0] prev_ff;
   logic [EVENT_BITS-1:0] prev_in;
   logic [EVENT_BITS-1:0] accum_ff;
   logic [EVENT_BITS-1:0] accum_in;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_ff;

   logic                  acc;
   logic                  out_free;
   logic                  emit;
   logic                  step;
   rsp_word_type          rsp_new;

   logic [EVENT_BITS-1:0] m_word;
   logic [EVENT_BITS-1:0] m_interest;
   logic                  m_all;
   logic [EVENT_BITS-1:0] m_hit;

   slot_cmd_type            cmd;
   slot_entry_type          wr_entry;
   slot_entry_type          entry;
   logic [IDX_W-1:0]        slot_idx;
   logic [WAITER_SLOTS-1:0] pending;
   logic [WAITER_SLOTS-1:0] expire;
   logic [WAITER_SLOTS-1:0] above;
   logic                    busy;
   logic                    is_post;
   logic                    pend_cur;
   logic                    fire;

   assign acc       = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_post   = (req_ff.op == OP_POST);

   assign slot_idx = IDX_W'(req_ff.waiter_slot);
   assign busy     = (32'(req_ff.waiter_slot) >= 32'(WAITER_SLOTS)) || pending[slot_idx];
   assign pend_cur = pending[idx_ff];

   // one match unit serves the wait test and every step of the post walk
   assign m_word     = (state_ff == S_WAIT && req_ff.reset_first) ? '0 : ew_ff;
   assign m_interest = (state_ff == S_WAIT) ? req_ff.value_bits : entry.interest;
   assign m_all      = (state_ff == S_WAIT) ? req_ff.require_all : entry.need_all;

   efg_match u_match (
      .word     (m_word),
      .interest (m_interest),
      .need_all (m_all),
      .hit      (m_hit)
   );

   assign wr_entry.interest = req_ff.value_bits;
   assign wr_entry.need_all = req_ff.require_all;
   assign wr_entry.consume  = req_ff.consume;
   assign wr_entry.endless  = &req_ff.timeout_ticks;
   assign wr_entry.ticks    = req_ff.timeout_ticks;

   efg_slot_table #(
      .WAITER_SLOTS (WAITER_SLOTS),
      .IDX_W        (IDX_W)
   ) u_slots (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_idx   (slot_idx),
      .wr_entry (wr_entry),
      .rd_idx   (idx_ff),
      .rd_entry (entry),
      .pending  (pending),
      .expire   (expire)
   );

   // slots above the walk position, for the last flag of a tick
   always_comb begin
      for (int j = 0; j < WAITER_SLOTS; j++) begin
         above[j] = (32'(j) > 32'(idx_ff));
      end
   end

   assign fire = is_post ? (pend_cur && (m_hit != '0)) : expire[idx_ff];

   // datapath and handshake controls
   always_comb begin
      emit     = 1'b0;
      step     = 1'b0;
      rsp_new  = '0;
      ew_in    = ew_ff;
      prev_in  = prev_ff;
      accum_in = accum_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (acc && req_word.op == OP_POST) begin
               prev_in  = ew_ff & req_word.post_mask;
               ew_in    = (ew_ff & ~req_word.post_mask) |
                          (req_word.value_bits & req_word.post_mask);
               accum_in = '0;
            end
         end
         S_WAIT: begin
            if (out_free) begin
               rsp_new.slot_id = req_ff.waiter_slot;
               rsp_new.last    = 1'b1;
               if (busy) begin
                  emit               = 1'b1;
                  rsp_new.status     = RS_SLOT_BUSY;
                  rsp_new.events_now = ew_ff;
               end else if (m_hit != '0) begin
                  emit                 = 1'b1;
                  ew_in                = req_ff.consume ? (m_word & ~m_hit) : m_word;
                  rsp_new.status       = RS_SATISFIED;
                  rsp_new.matched_bits = m_hit;
                  rsp_new.events_now   = ew_in;
               end else if (req_ff.timeout_ticks == '0) begin
                  emit               = 1'b1;
                  ew_in              = m_word;
                  rsp_new.status     = RS_NO_WAIT;
                  rsp_new.events_now = m_word;
               end else begin
                  ew_in    = m_word;
                  cmd.park = 1'b1;
               end
            end
         end
         S_WALK: begin
            if (!fire || out_free) begin
               step   = 1'b1;
               idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
               rsp_new.slot_id    = SLOT_BITS'(idx_ff);
               rsp_new.events_now = ew_ff;
               if (fire) begin
                  emit     = 1'b1;
                  cmd.free = 1'b1;
                  if (is_post) begin
                     rsp_new.status       = RS_WOKEN;
                     rsp_new.matched_bits = m_hit;
                     if (entry.consume) begin
                        accum_in = accum_ff | m_hit;
                     end
                  end else begin
                     rsp_new.status = RS_TIMED_OUT;
                     rsp_new.last   = ((expire & above) == '0);
                  end
               end else if (!is_post && pend_cur && !entry.endless) begin
                  cmd.dec = 1'b1;
               end
            end
         end
         S_ACK: begin
            if (out_free) begin
               emit                  = 1'b1;
               ew_in                 = ew_ff & ~accum_ff;
               rsp_new.status        = RS_POST_DONE;
               rsp_new.previous_bits = prev_ff;
               rsp_new.events_now    = ew_in;
               rsp_new.last          = 1'b1;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               case (req_word.op)
                  OP_POST, OP_TICK: state_in = S_WALK;
                  OP_WAIT:          state_in = S_WAIT;
                  default:          state_in = S_IDLE;
               endcase
            end
         end
         S_WAIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (step && idx_ff == LAST_IDX) begin
               state_in = is_post ? S_ACK : S_IDLE;
            end
         end
         S_ACK: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ew_ff        <= '0;
         prev_ff      <= '0;
         accum_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ew_ff    <= ew_in;
         prev_ff  <= prev_in;
         accum_ff <= accum_in;
         idx_ff   <= idx_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the item and the outgoing word
   always_ff @(posedge clock) begin
      if (acc) begin
         req_ff <= req_word;
      end
      if (emit) begin
         rsp_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_ack_after_post: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACK) |-> is_post)
      else $error("acknowledgement state outside a post");

   a_accum_in_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && is_post) |-> ((accum_ff & ~ew_ff) == '0))
      else $error("consume bits outside the posted word");

   a_no_emit_on_accept: assert property (@(posedge clock) disable iff (reset)
      acc |-> !emit)
      else $error("result word produced while accepting an item");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && step && idx_ff == LAST_IDX && !is_post) |=>
         (state_ff == S_IDLE))
      else $error("tick walk did not return to idle");

endmodule

// File: design/efg_match.sv
// Shared match unit: any-of or all-of test of an event word against an interest set.
// Depends on efg_pkg.
module efg_match (
   input  logic [efg_pkg::EVENT_BITS-1:0] word,
   input  logic [efg_pkg::EVENT_BITS-1:0] interest,
   input  logic                           need_all,
   output logic [efg_pkg::EVENT_BITS-1:0] hit
);
   import efg_pkg::*;

   logic [EVENT_BITS-1:0] raw;

   assign raw = word & interest;
   // all-of mode: a partial hit counts as no hit
   assign hit = (need_all && (raw != interest)) ? '0 : raw;

endmodule

// File: design/efg_slot_table.sv
// Waiter slot table: pending flags in flip-flops, entry payload without reset.
// Depends on efg_pkg; driven by the sequencer in event_flag_group_with_waiters.
module efg_slot_table #(
   parameter int WAITER_SLOTS = efg_pkg::DEF_WAITER_SLOTS,
   parameter int IDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  efg_pkg::slot_cmd_type        cmd,
   input  logic [IDX_W-1:0]             wr_idx,
   input  efg_pkg::slot_entry_type      wr_entry,
   input  logic [IDX_W-1:0]             rd_idx,
   output efg_pkg::slot_entry_type      rd_entry,
   output logic [WAITER_SLOTS-1:0]      pending,
   output logic [WAITER_SLOTS-1:0]      expire
);
   import efg_pkg::*;

   slot_entry_type            table_ff [WAITER_SLOTS];
   logic [WAITER_SLOTS-1:0]   pending_ff;
   logic [WAITER_SLOTS-1:0]   pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (cmd.park) begin
         pending_in[wr_idx] = 1'b1;
      end
      if (cmd.free) begin
         pending_in[rd_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.park) begin
         table_ff[wr_idx] <= wr_entry;
      end
      if (cmd.dec) begin
         table_ff[rd_idx].ticks <= table_ff[rd_idx].ticks - 1'b1;
      end
   end

   // a slot expires on the next tick when it has one tick or none left
   always_comb begin
      for (int i = 0; i < WAITER_SLOTS; i++) begin
         expire[i] = pending_ff[i] && !table_ff[i].endless &&
                     (table_ff[i].ticks[TIMEOUT_BITS-1:1] == '0);
      end
   end

   assign rd_entry = table_ff[rd_idx];
   assign pending  = pending_ff;

   a_park_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.park |-> !pending_ff[wr_idx])
      else $error("park into a pending slot");

   a_free_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.free |-> pending_ff[rd_idx])
      else $error("free of a slot that is not pending");

   a_dec_live: assert property (@(posedge clock) disable iff (reset)
      cmd.dec |-> (pending_ff[rd_idx] && !expire[rd_idx] && !cmd.free))
      else $error("countdown on an idle or expiring slot");

endmodule

// File: tb/sv/event_flag_group_with_waiters_tb.sv
// Self-checking testbench for event_flag_group_with_waiters: directed rows, then random
// traffic, checked word by word against an in-bench model of the flag word and waiter slots.
// Depends on efg_pkg and the event_flag_group_with_waiters RTL.
`timescale 1ns / 100ps

module event_flag_group_with_waiters_tb;
   import efg_pkg::*;

   localparam int           SLOTS        = DEF_WAITER_SLOTS;
   localparam int           CYCLE_LIMIT  = 200000;
   localparam int           DRAIN_CYCLES = 40;
   localparam int           RAND_ITEMS   = 90;
   localparam logic [1:0]   OP_UNUSED    = 2'd3;
   localparam logic [15:0]  TICKS_NONE   = 16'd0;
   localparam logic [15:0]  TICKS_FOREVER = 16'hFFFF;
   localparam logic [31:0]  ALL_ONES     = 32'hFFFF_FFFF;

   typedef struct {
      req_word_type w;
      bit           typed;
      rsp_word_type exp;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   // model of the block
   logic [31:0]  ev_word;
   logic         wt_pending [SLOTS];
   logic [31:0]  wt_interest [SLOTS];
   logic         wt_need_all [SLOTS];
   logic         wt_consume [SLOTS];
   logic         wt_forever [SLOTS];
   logic [15:0]  wt_ticks [SLOTS];

   rsp_word_type expected_rsps [$];
   dir_row_type  dir_rows [$];
   int           fail_count = 0;
   int           cycles = 0;
   bit           calm;
   bit           cur_typed;
   rsp_word_type cur_exp;

   event_flag_group_with_waiters dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #10 clock = ~clock;

   function automatic req_word_type mk_req(logic [1:0] op, logic [31:0] val,
                                           logic [31:0] mask, logic [2:0] slot,
                                           logic all, logic rst, logic cons,
                                           logic [15:0] tmo);
      req_word_type w;
      w.op            = op;
      w.value_bits    = val;
      w.post_mask     = mask;
      w.waiter_slot   = slot;
      w.require_all   = all;
      w.reset_first   = rst;
      w.consume       = cons;
      w.timeout_ticks = tmo;
      return w;
   endfunction

   function automatic rsp_word_type mk_rsp(status_type st, logic [2:0] slot,
                                           logic [31:0] matched, logic [31:0] prev,
                                           logic [31:0] now);
      rsp_word_type r;
      r.status        = st;
      r.slot_id       = slot;
      r.matched_bits  = matched;
      r.previous_bits = prev;
      r.events_now    = now;
      r.last          = 1'b0;
      return r;
   endfunction

   function automatic rsp_word_type mk_last(status_type st, logic [2:0] slot,
                                            logic [31:0] matched, logic [31:0] prev,
                                            logic [31:0] now);
      rsp_word_type r;
      r      = mk_rsp(st, slot, matched, prev, now);
      r.last = 1'b1;
      return r;
   endfunction

   function automatic logic [31:0] match_hit(logic [31:0] word, logic [31:0] interest,
                                             logic all);
      logic [31:0] hit;
      hit = word & interest;
      if (all && hit != interest)
         hit = '0;
      return hit;
   endfunction

   function automatic void reset_flags();
      ev_word = '0;
      for (int i = 0; i < SLOTS; i++) begin
         wt_pending[i]  = 1'b0;
         wt_interest[i] = '0;
         wt_need_all[i] = 1'b0;
         wt_consume[i]  = 1'b0;
         wt_forever[i]  = 1'b0;
         wt_ticks[i]    = '0;
      end
   endfunction

   // Advance the model by one accepted word and queue the result words it causes.
   function automatic void predict_flags(req_word_type w);
      logic [31:0] prev;
      logic [31:0] accum;
      logic [31:0] hit;
      int          n0;
      int          s;
      n0 = expected_rsps.size();
      s  = w.waiter_slot;
      case (w.op)
         OP_POST: begin
            prev    = ev_word & w.post_mask;
            accum   = '0;
            ev_word = (ev_word & ~w.post_mask) | (w.value_bits & w.post_mask);
            // all slots judged against the posted word; clears come after the walk
            for (int i = 0; i < SLOTS; i++) begin
               if (wt_pending[i]) begin
                  hit = match_hit(ev_word, wt_interest[i], wt_need_all[i]);
                  if (hit != '0) begin
                     wt_pending[i] = 1'b0;
                     if (wt_consume[i])
                        accum |= hit;
                     expected_rsps.push_back(mk_rsp(RS_WOKEN, 3'(i), hit, '0, ev_word));
                  end
               end
            end
            ev_word &= ~accum;
            expected_rsps.push_back(mk_rsp(RS_POST_DONE, '0, '0, prev, ev_word));
         end
         OP_WAIT: begin
            if (wt_pending[s]) begin
               expected_rsps.push_back(mk_rsp(RS_SLOT_BUSY, 3'(s), '0, '0, ev_word));
            end else begin
               if (w.reset_first)
                  ev_word = '0;
               hit = match_hit(ev_word, w.value_bits, w.require_all);
               if (hit != '0) begin
                  if (w.consume)
                     ev_word &= ~hit;
                  expected_rsps.push_back(mk_rsp(RS_SATISFIED, 3'(s), hit, '0, ev_word));
               end else if (w.timeout_ticks == TICKS_NONE) begin
                  expected_rsps.push_back(mk_rsp(RS_NO_WAIT, 3'(s), '0, '0, ev_word));
               end else begin
                  wt_pending[s]  = 1'b1;
                  wt_interest[s] = w.value_bits;
                  wt_need_all[s] = w.require_all;
                  wt_consume[s]  = w.consume;
                  wt_forever[s]  = (w.timeout_ticks == TICKS_FOREVER);
                  wt_ticks[s]    = w.timeout_ticks;
               end
            end
         end
         OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (wt_pending[i] && !wt_forever[i]) begin
                  if (wt_ticks[i] <= 16'd1) begin
                     wt_pending[i] = 1'b0;
                     wt_ticks[i]   = '0;
                     expected_rsps.push_back(mk_rsp(RS_TIMED_OUT, 3'(i), '0, '0,
                                                    ev_word));
                  end else begin
                     wt_ticks[i] = wt_ticks[i] - 16'd1;
                  end
               end
            end
         end
         default: ;
      endcase
      if (expected_rsps.size() > n0)
         expected_rsps[expected_rsps.size() - 1].last = 1'b1;
   endfunction

   task automatic check_rsp(rsp_word_type got);
      rsp_word_type exp;
      if (expected_rsps.size() == 0) begin
         $error("result word with nothing expected: status %0d slot %0d",
                got.status, got.slot_id);
         fail_count++;
      end else begin
         exp = expected_rsps.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            fail_count++;
         end
         if (got.slot_id !== exp.slot_id) begin
            $error("slot_id: expected %0d, got %0d", exp.slot_id, got.slot_id);
            fail_count++;
         end
         if (got.matched_bits !== exp.matched_bits) begin
            $error("matched_bits: expected %h, got %h", exp.matched_bits, got.matched_bits);
            fail_count++;
         end
         if (got.previous_bits !== exp.previous_bits) begin
            $error("previous_bits: expected %h, got %h", exp.previous_bits,
                   got.previous_bits);
            fail_count++;
         end
         if (got.events_now !== exp.events_now) begin
            $error("events_now: expected %h, got %h", exp.events_now, got.events_now);
            fail_count++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            fail_count++;
         end
      end
   endtask

   // Check result words first, then predict from the word accepted at this edge.
   always @(posedge clock) begin
      int n0;
      if (reset) begin
         reset_flags();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_rsp(rsp_word);
         if (req_valid && !req_stall) begin
            n0 = expected_rsps.size();
            predict_flags(req_word);
            if (cur_typed) begin
               while (expected_rsps.size() > n0)
                  void'(expected_rsps.pop_back());
               expected_rsps.push_back(cur_exp);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Result side stall: short runs mostly, a long hold now and then.
   initial begin
      int hold;
      int r;
      hold      = 0;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_stall <= 1'b0;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_stall <= 1'b0;
               hold = $urandom_range(0, 4);
            end else if (r < 93) begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(10, 40);
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(req_word_type w, bit typed, rsp_word_type exp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      cur_typed = typed;
      cur_exp   = exp;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_bits();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return $urandom_range(1, 255);
      else if (r < 75)
         return $urandom;
      else if (r < 85)
         return ALL_ONES;
      else
         return 32'd1 << $urandom_range(0, 31);
   endfunction

   function automatic logic [15:0] rand_ticks();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20)
         return TICKS_NONE;
      else if (r < 60)
         return 16'($urandom_range(1, 8));
      else if (r < 70)
         return TICKS_FOREVER;
      else if (r < 80)
         return TICKS_FOREVER - 16'd1;
      else
         return 16'($urandom_range(0, 65535));
   endfunction

   function automatic req_word_type rand_req();
      req_word_type w;
      int           r;
      int           k;
      r = $urandom_range(0, 99);
      w = mk_req(OP_WAIT, rand_bits(), $urandom, 3'($urandom_range(0, SLOTS - 1)),
                 1'($urandom_range(0, 1)), ($urandom_range(0, 99) < 15),
                 1'($urandom_range(0, 1)), rand_ticks());
      if (r < 35) begin
         w.op = OP_POST;
         k = $urandom_range(0, 99);
         if (k < 30) begin
            w.post_mask  = ALL_ONES;
            w.value_bits = rand_bits();
         end else if (k < 55) begin
            w.value_bits = ALL_ONES;
            w.post_mask  = rand_bits();
         end else if (k < 75) begin
            w.value_bits = '0;
            w.post_mask  = rand_bits();
         end else begin
            w.value_bits = $urandom;
            w.post_mask  = $urandom;
         end
      end else if (r < 82) begin
         // a forever waiter with no interest would hold its slot for good
         if (w.timeout_ticks == TICKS_FOREVER && w.value_bits == '0)
            w.timeout_ticks = 16'd3;
      end else if (r < 95) begin
         w.op = OP_TICK;
      end else begin
         w.op = OP_UNUSED;
      end
      return w;
   endfunction

   function automatic void add_row(req_word_type w, bit typed, rsp_word_type exp);
      dir_row_type row;
      row.w     = w;
      row.typed = typed;
      row.exp   = exp;
      dir_rows.push_back(row);
   endfunction

   function automatic void build_rows();
      rsp_word_type none;
      none = '0;
      add_row(mk_req(OP_POST, ALL_ONES, ALL_ONES, 0, 0, 0, 0, 0), 1,
              mk_last(RS_POST_DONE, 0, '0, '0, ALL_ONES));
      add_row(mk_req(OP_POST, '0, ALL_ONES, 0, 0, 0, 0, 0), 1,
              mk_last(RS_POST_DONE, 0, '0, ALL_ONES, '0));
      add_row(mk_req(OP_WAIT, 32'h1, '0, 0, 0, 0, 0, TICKS_NONE), 1,
              mk_last(RS_NO_WAIT, 0, '0, '0, '0));
      add_row(mk_req(OP_POST, 32'hF0, ALL_ONES, 0, 0, 0, 0, 0), 1,
              mk_last(RS_POST_DONE, 0, '0, '0, 32'hF0));
      add_row(mk_req(OP_WAIT, 32'h30, '0, 1, 0, 0, 1, TICKS_NONE), 1,
              mk_last(RS_SATISFIED, 1, 32'h30, '0, 32'hC0));
      add_row(mk_req(OP_WAIT, 32'hC1, '0, 2, 1, 0, 0, 16'd5), 0, none);
      add_row(mk_req(OP_WAIT, 32'h1, '0, 2, 0, 0, 0, TICKS_NONE), 1,
              mk_last(RS_SLOT_BUSY, 2, '0, '0, 32'hC0));
      // no interest bits: this waiter can only time out
      add_row(mk_req(OP_WAIT, '0, '0, 3, 0, 0, 0, 16'd2), 0, none);
      add_row(mk_req(OP_WAIT, 32'h8000_0000, '0, 4, 0, 0, 1, TICKS_FOREVER), 0, none);
      add_row(mk_req(OP_WAIT, 32'h40, '0, 5, 0, 1, 0, 16'd1), 0, none);
      add_row(mk_req(OP_TICK, '0, '0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_req(OP_TICK, '0, '0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_req(OP_POST, 32'h8000_00C1, ALL_ONES, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_req(OP_UNUSED, ALL_ONES, ALL_ONES, 7, 1, 1, 1, TICKS_FOREVER), 0, none);
      add_row(mk_req(OP_WAIT, ALL_ONES, '0, 6, 1, 1, 1, TICKS_NONE), 1,
              mk_last(RS_NO_WAIT, 6, '0, '0, '0));
      add_row(mk_req(OP_POST, ALL_ONES, 32'h0000_FFFF, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_req(OP_WAIT, ALL_ONES, '0, 7, 1, 0, 0, TICKS_FOREVER - 16'd1), 0, none);
      // fill every slot, then wake them all with one post
      for (int i = 0; i < SLOTS - 1; i++)
         add_row(mk_req(OP_WAIT, 32'd1 << (16 + i), '0, 3'(i), 0, 0, 1'(i % 2),
                        TICKS_FOREVER), 0, none);
      add_row(mk_req(OP_POST, ALL_ONES, ALL_ONES, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_req(OP_TICK, ALL_ONES, ALL_ONES, 7, 1, 1, 1, TICKS_FOREVER), 0, none);
   endfunction

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      rsp_word_type none;
      none       = '0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_word   = '0;
      cur_typed  = 1'b0;
      cur_exp    = '0;
      calm       = 1'b0;
      build_rows();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].exp);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         calm = (n % 40) >= 28;
         // flush parked waiters now and then so slots keep turning over
         if (n % 16 == 15)
            send_word(mk_req(OP_POST, ALL_ONES, ALL_ONES, 0, 0, 0, 0, 0), 0, none);
         else
            send_word(rand_req(), 0, none);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_rsps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
design/efg_pkg.sv
design/efg_match.sv
design/efg_slot_table.sv
design/event_flag_group_with_waiters.sv
tb/sv/event_flag_group_with_waiters_tb.sv
